// ----- rtl/ksc_pkg.sv -----
`timescale 1ns / 1ps

package ksc_pkg;

    localparam int ALPHA_SIZE = 26;
    localparam int IDX_W      = 5;
    localparam int CHAR_W     = 8;

    localparam logic [IDX_W-1:0]  LAST_IDX    = IDX_W'(ALPHA_SIZE - 1);
    localparam logic [IDX_W-1:0]  FULL_COUNT  = IDX_W'(ALPHA_SIZE);
    localparam logic [CHAR_W-1:0] UPPER_FIRST = 8'h41;  // 'A'
    localparam logic [CHAR_W-1:0] UPPER_LAST  = 8'h5A;  // 'Z'
    localparam logic [CHAR_W-1:0] LOWER_FIRST = 8'h61;  // 'a'
    localparam logic [CHAR_W-1:0] LOWER_LAST  = 8'h7A;  // 'z'

    typedef enum logic [2:0] {
        CMD_CLEAR = 3'd0,
        CMD_KEY   = 3'd1,
        CMD_FINAL = 3'd2,
        CMD_ENC   = 3'd3,
        CMD_DEC   = 3'd4
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_READY = 2'd1,
        ST_KEY_LATE  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_FILL,
        S_INVERT
    } state_t;

    // Operations on the alphabet store
    typedef enum logic [1:0] {
        OP_NONE,
        OP_CLEAR,
        OP_PLACE,
        OP_INV
    } tab_op_t;

    typedef struct packed {
        tab_op_t          op;
        logic [IDX_W-1:0] letter;     // letter to place, or inverse entry value
        logic [IDX_W-1:0] addr;       // read address of both tables
        logic             set_ready;  // mark tables finalized
    } tab_ctl_t;

    typedef struct packed {
        logic             ready;
        logic [IDX_W-1:0] fwd_data;
        logic [IDX_W-1:0] inv_data;
    } tab_stat_t;

    typedef struct packed {
        logic             is_letter;
        logic [IDX_W-1:0] idx;
    } letter_t;

    // Map an ASCII byte of either case to a letter index
    function automatic letter_t decode_letter(logic [CHAR_W-1:0] ch);
        letter_t          res;
        logic [CHAR_W-1:0] diff;
        res  = '0;
        diff = '0;
        if (ch >= UPPER_FIRST && ch <= UPPER_LAST) begin
            diff          = ch - UPPER_FIRST;
            res.is_letter = 1'b1;
        end else if (ch >= LOWER_FIRST && ch <= LOWER_LAST) begin
            diff          = ch - LOWER_FIRST;
            res.is_letter = 1'b1;
        end
        res.idx = diff[IDX_W-1:0];
        return res;
    endfunction

endpackage

// ----- rtl/ksc_alpha.sv -----
`timescale 1ns / 1ps

module ksc_alpha import ksc_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  tab_ctl_t  ctl,
    output tab_stat_t stat
);

    logic [IDX_W-1:0]      fwd_mem [ALPHA_SIZE];
    logic [IDX_W-1:0]      inv_mem [ALPHA_SIZE];
    logic [ALPHA_SIZE-1:0] used_reg;
    logic [ALPHA_SIZE-1:0] used_next;
    logic [IDX_W-1:0]      fill_reg;
    logic [IDX_W-1:0]      fill_next;
    logic                  ready_reg;
    logic                  ready_next;
    logic                  place_en;
    logic [IDX_W-1:0]      fwd_rd;

    // Place a letter only if unused and the alphabet still has room
    assign place_en = (ctl.op == OP_PLACE) && !used_reg[ctl.letter]
                      && (fill_reg < FULL_COUNT);
    assign fwd_rd   = fwd_mem[ctl.addr];

    // Next control state
    always_comb begin
        used_next  = used_reg;
        fill_next  = fill_reg;
        ready_next = ready_reg;
        case (ctl.op)
            OP_CLEAR: begin
                used_next  = '0;
                fill_next  = '0;
                ready_next = 1'b0;
            end
            OP_PLACE: begin
                if (place_en) begin
                    used_next[ctl.letter] = 1'b1;
                    fill_next             = fill_reg + 1'b1;
                end
            end
            OP_INV: begin
                if (ctl.set_ready) begin
                    ready_next = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg  <= '0;
            fill_reg  <= '0;
            ready_reg <= 1'b0;
        end else begin
            used_reg  <= used_next;
            fill_reg  <= fill_next;
            ready_reg <= ready_next;
        end
    end

    // Write the substitution tables
    always_ff @(posedge aclk) begin
        if (place_en) begin
            fwd_mem[fill_reg] <= ctl.letter;
        end
        if (ctl.op == OP_INV) begin
            inv_mem[fwd_rd] <= ctl.letter;
        end
    end

    assign stat.ready    = ready_reg;
    assign stat.fwd_data = fwd_rd;
    assign stat.inv_data = inv_mem[ctl.addr];

    // Every placed letter is counted exactly once
    a_fill_matches_used: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg == IDX_W'($countones(used_reg)))
        else $error("fill count disagrees with used letters");

    // Finalized tables always hold a full alphabet
    a_ready_full: assert property (@(posedge aclk) disable iff (!aresetn)
        ready_reg |-> fill_reg == FULL_COUNT)
        else $error("tables ready with partial alphabet");

    // The last inverse step finalizes the tables
    a_set_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctl.op == OP_INV && ctl.set_ready) |=> ready_reg)
        else $error("tables not ready after inverse pass");

endmodule

// ----- rtl/keyword_substitution_cipher_unit.sv -----
`timescale 1ns / 1ps

// Keyword substitution cipher. Each input word carries a command in s_tuser and a
// byte in s_tdata; every input word yields exactly one output word with the byte
// (mapped or echoed) in m_tdata and a status code in m_tuser. Clear, key letter,
// encrypt, decrypt and unused commands load their result word on acceptance, so
// those words stream at one per cycle while the output is drained. Finalize
// accepts its byte, then a single shared index counter walks the 26 letters once
// to complete the forward alphabet and once more to build the inverse table. The
// result word is loaded on the last inverse step, and s_tready stays low through
// both walks. No clearing pass follows reset.
module keyword_substitution_cipher_unit import ksc_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_char
    input  logic [2:0]  s_tuser,   // [2:0] cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] out_char
    output logic [1:0]  m_tuser    // [1:0] status
);

    state_t            state_reg;
    state_t            state_next;
    logic [IDX_W-1:0]  step_reg;
    logic [IDX_W-1:0]  step_next;
    logic [CHAR_W-1:0] char_reg;
    logic              m_valid_reg;
    logic [CHAR_W-1:0] m_char_reg;
    status_t           m_status_reg;
    logic              s_accept;
    letter_t           in_letter;
    cmd_t              in_cmd;
    tab_ctl_t          ctl;
    tab_stat_t         stat;
    logic              out_load;
    logic [CHAR_W-1:0] out_char_next;
    status_t           out_status_next;

    assign in_cmd    = cmd_t'(s_tuser);
    assign in_letter = decode_letter(s_tdata);
    assign s_tready  = (state_reg == S_IDLE) && (!m_valid_reg || m_tready);
    assign s_accept  = s_tvalid && s_tready;

    ksc_alpha u_alpha (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (ctl),
        .stat    (stat)
    );

    // Next state of the sequencer
    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        case (state_reg)
            S_IDLE: begin
                step_next = '0;
                if (s_accept && in_cmd == CMD_FINAL) begin
                    state_next = S_FILL;
                end
            end
            S_FILL: begin
                if (step_reg == LAST_IDX) begin
                    state_next = S_INVERT;
                    step_next  = '0;
                end else begin
                    step_next = step_reg + 1'b1;
                end
            end
            S_INVERT: begin
                if (step_reg == LAST_IDX) begin
                    state_next = S_IDLE;
                    step_next  = '0;
                end else begin
                    step_next = step_reg + 1'b1;
                end
            end
            default: begin
                state_next = S_IDLE;
                step_next  = '0;
            end
        endcase
    end

    // Table commands and result word
    always_comb begin
        ctl             = '0;
        ctl.op          = OP_NONE;
        ctl.letter      = in_letter.idx;
        ctl.addr        = in_letter.idx;
        out_load        = 1'b0;
        out_char_next   = s_tdata;
        out_status_next = ST_OK;
        case (state_reg)
            S_IDLE: begin
                if (s_accept) begin
                    out_load = (in_cmd != CMD_FINAL);
                    case (in_cmd)
                        CMD_CLEAR: begin
                            ctl.op = OP_CLEAR;
                        end
                        CMD_KEY: begin
                            if (stat.ready) begin
                                out_status_next = ST_KEY_LATE;
                            end else if (in_letter.is_letter) begin
                                ctl.op = OP_PLACE;
                            end
                        end
                        CMD_ENC: begin
                            if (!stat.ready) begin
                                out_status_next = ST_NOT_READY;
                            end else if (in_letter.is_letter) begin
                                out_char_next = UPPER_FIRST + {3'b000, stat.fwd_data};
                            end
                        end
                        CMD_DEC: begin
                            if (!stat.ready) begin
                                out_status_next = ST_NOT_READY;
                            end else if (in_letter.is_letter) begin
                                out_char_next = UPPER_FIRST + {3'b000, stat.inv_data};
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_FILL: begin
                ctl.op     = OP_PLACE;
                ctl.letter = step_reg;
            end
            S_INVERT: begin
                ctl.op        = OP_INV;
                ctl.letter    = step_reg;
                ctl.addr      = step_reg;
                ctl.set_ready = (step_reg == LAST_IDX);
                out_load      = (step_reg == LAST_IDX);
                out_char_next = char_reg;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            step_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Hold the finalize byte for its echo; load the result word
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            char_reg <= s_tdata;
        end
        if (out_load) begin
            m_char_reg   <= out_char_next;
            m_status_reg <= out_status_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_char_reg;
    assign m_tuser  = m_status_reg;

endmodule
